// ===== src/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Field widths, operation and status codes, and the item and queue-control types
// used by the allocator and its freed-slot queue.
// ----------------------------------------------------------------------------
package gha_pkg;

    localparam int IN_IDX_W     = 10;
    localparam int IN_GEN_W     = 8;
    localparam int THR_W        = 11;
    localparam int DEF_SLOTS    = 1024;
    localparam int DEF_GEN_BITS = 8;

    localparam logic [THR_W-1:0] THR_RESET = 11'd1024;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;

    localparam logic [1:0] ST_DONE         = 2'd0;
    localparam logic [1:0] ST_NOT_ALIVE    = 2'd1;
    localparam logic [1:0] ST_NO_SLOT      = 2'd2;
    localparam logic [1:0] ST_NO_TRANSFORM = 2'd3;

    typedef struct packed {
        logic [1:0]          operation;
        logic                has_transform;
        logic [IN_IDX_W-1:0] slot_index;
        logic [IN_GEN_W-1:0] generation;
    } t_in;

    typedef struct packed {
        logic [1:0]          status;
        logic [IN_IDX_W-1:0] out_index;
        logic [IN_GEN_W-1:0] out_generation;
        logic                alive;
    } t_out;

    typedef struct packed {
        logic push;
        logic pop;
        logic rd_en;
    } t_fifo_ctl;

endpackage

// ===== src/generational_handle_allocator_top.sv =====
// ----------------------------------------------------------------------------
// An accepted item waits in the input register until its result is registered.
// Throughput: one item per cycle while the output is not stalled; the slot table
// and queue each take one read and one write per cycle, with same-cycle writes
// forwarded to reads. Reset clears the control state and sets the reuse threshold
// to 1024. The tables are not cleared: only entries of slots below the used-slot count are used.
// ----------------------------------------------------------------------------
// Generational handle allocator
// Creates, removes and checks handles made of a slot index and a generation.
// ----------------------------------------------------------------------------
module generational_handle_allocator_top #(
    parameter int SLOTS    = gha_pkg::DEF_SLOTS,
    parameter int GEN_BITS = gha_pkg::DEF_GEN_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [gha_pkg::THR_W-1:0]  i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  gha_pkg::t_in               i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output gha_pkg::t_out              o_out
);
    import gha_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS+1);
    localparam int AXW   = (IDX_W > IN_IDX_W) ? IDX_W : IN_IDX_W;
    localparam int UXW   = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;
    localparam int GXW   = (GEN_BITS > IN_GEN_W) ? GEN_BITS : IN_GEN_W;
    localparam int TXW   = (CNT_W > THR_W) ? CNT_W : THR_W;

    // Slot table entry: live bit above the generation.
    logic [GEN_BITS:0]   slot_mem [SLOTS];
    logic [GEN_BITS:0]   r_slot_rd;

    logic [THR_W-1:0]    r_thr;
    logic                r_v;
    t_in                 r_in;
    logic                r_ov;
    t_out                r_out;
    logic [CNT_W-1:0]    r_used, n_used;

    logic                fire;
    logic                in_accept;
    t_out                res;
    t_fifo_ctl           fctl;
    logic [IDX_W+GEN_BITS-1:0] fifo_rd;
    logic [CNT_W-1:0]    fifo_count;

    logic [AXW-1:0]      rd_addr_x;
    logic [IDX_W-1:0]    rd_addr;
    logic [AXW-1:0]      in_addr_x;
    logic [IDX_W-1:0]    in_addr;
    logic                hit;
    logic                make;
    logic [IDX_W-1:0]    new_idx;
    logic [GEN_BITS-1:0] new_gen;
    logic [AXW-1:0]      oidx_x;
    logic [GXW-1:0]      ogen_x;
    logic                slot_we;
    logic [IDX_W-1:0]    slot_waddr;
    logic [GEN_BITS:0]   slot_wdata;

    assign fire       = r_v && (!r_ov || !i_out_stall);
    assign o_in_stall = r_v && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign rd_addr_x = AXW'(i_in.slot_index);
    assign rd_addr   = rd_addr_x[IDX_W-1:0];
    assign in_addr_x = AXW'(r_in.slot_index);
    assign in_addr   = in_addr_x[IDX_W-1:0];

    assign hit = (UXW'(r_in.slot_index) < UXW'(r_used))
              && r_slot_rd[GEN_BITS]
              && (GXW'(r_slot_rd[GEN_BITS-1:0]) == GXW'(r_in.generation));

    always_comb begin
        res        = '0;
        res.status = ST_DONE;
        fctl.push  = 1'b0;
        fctl.pop   = 1'b0;
        fctl.rd_en = in_accept;
        n_used     = r_used;
        make       = 1'b0;
        new_idx    = '0;
        new_gen    = '0;
        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_wdata = '0;
        oidx_x     = '0;
        ogen_x     = '0;

        case (r_in.operation)
            OP_CREATE: begin
                if (!r_in.has_transform) begin
                    res.status = ST_NO_TRANSFORM;
                end else if (TXW'(fifo_count) > TXW'(r_thr)) begin
                    // Recycle the oldest freed slot with the next generation.
                    fctl.pop = fire;
                    new_idx  = fifo_rd[IDX_W-1:0];
                    new_gen  = fifo_rd[IDX_W+GEN_BITS-1:IDX_W] + 1'b1;
                    make     = 1'b1;
                end else if (r_used < CNT_W'(SLOTS)) begin
                    new_idx = r_used[IDX_W-1:0];
                    make    = 1'b1;
                    if (fire) begin
                        n_used = r_used + 1'b1;
                    end
                end else begin
                    res.status = ST_NO_SLOT;
                end
                if (make) begin
                    slot_we            = fire;
                    slot_waddr         = new_idx;
                    slot_wdata         = {1'b1, new_gen};
                    oidx_x             = AXW'(new_idx);
                    ogen_x             = GXW'(new_gen);
                    res.out_index      = oidx_x[IN_IDX_W-1:0];
                    res.out_generation = ogen_x[IN_GEN_W-1:0];
                    res.alive          = 1'b1;
                end
            end
            OP_REMOVE, OP_CHECK: begin
                if (hit) begin
                    res.alive = 1'b1;
                    if (r_in.operation == OP_REMOVE) begin
                        slot_we    = fire;
                        slot_waddr = in_addr;
                        slot_wdata = {1'b0, r_slot_rd[GEN_BITS-1:0]};
                        fctl.push  = fire;
                    end
                end else begin
                    res.status = ST_NOT_ALIVE;
                end
            end
            default: begin
            end
        endcase
    end

    gha_free_fifo #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS)
    ) u_free_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (fctl),
        .i_push_data ({r_slot_rd[GEN_BITS-1:0], in_addr}),
        .o_rd_data   (fifo_rd),
        .o_count     (fifo_count)
    );

    // The entering item reads the slot it names; a write to that slot by the
    // item leaving the input register in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (in_accept) begin
            r_slot_rd <= (slot_we && (slot_waddr == rd_addr)) ? slot_wdata
                                                              : slot_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_RESET;
            r_v    <= 1'b0;
            r_ov   <= 1'b0;
            r_used <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            r_used <= n_used;
            if (in_accept) begin
                r_v <= 1'b1;
            end else if (fire) begin
                r_v <= 1'b0;
            end
            if (fire) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(SLOTS))
        else $error("used-slot count beyond the table depth");

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= r_used)
        else $error("more freed slots queued than slots ever used");

    a_fresh_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_in.operation == OP_CREATE) && r_in.has_transform && !fctl.pop
        && (r_used < CNT_W'(SLOTS)) |=> r_used == $past(r_used) + 1'b1)
        else $error("fresh create did not advance the used-slot count");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_v && r_ov)
        else $error("input stalled with a free input register");

    a_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fctl.push && fctl.pop))
        else $error("one item both pushed and popped the freed-slot queue");

endmodule

// ===== src/gha_free_fifo.sv =====
// ----------------------------------------------------------------------------
// Freed-slot queue
// Circular queue of released slots, each stored with its generation. The head
// entry is read into a register whenever a new item enters the allocator.
// ----------------------------------------------------------------------------
module gha_free_fifo #(
    parameter int SLOTS    = gha_pkg::DEF_SLOTS,
    parameter int GEN_BITS = gha_pkg::DEF_GEN_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  gha_pkg::t_fifo_ctl                    i_ctl,
    input  logic [$clog2(SLOTS)+GEN_BITS-1:0]     i_push_data,
    output logic [$clog2(SLOTS)+GEN_BITS-1:0]     o_rd_data,
    output logic [$clog2(SLOTS+1)-1:0]            o_count
);
    import gha_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS+1);
    localparam int DW    = IDX_W + GEN_BITS;

    logic [DW-1:0]    mem [SLOTS];
    logic [DW-1:0]    r_rd;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W:0]   wr_sum;
    logic [IDX_W-1:0] wr_addr;
    logic             do_push;

    always_comb begin
        // Tail position is head plus count, wrapped once at the queue depth.
        wr_sum = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_count);
        if (wr_sum >= (CNT_W+1)'(SLOTS)) begin
            wr_sum = wr_sum - (CNT_W+1)'(SLOTS);
        end
        wr_addr = wr_sum[IDX_W-1:0];
        do_push = i_ctl.push && (r_count < CNT_W'(SLOTS));

        n_head = r_head;
        if (i_ctl.pop) begin
            n_head = (r_head == IDX_W'(SLOTS-1)) ? '0 : r_head + 1'b1;
        end
        n_count = r_count;
        if (do_push) begin
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // The next item sees the head after the current item's update, so a push
    // landing on that entry in the same cycle is passed straight through.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[wr_addr] <= i_push_data;
        end
        if (i_ctl.rd_en) begin
            r_rd <= (do_push && (wr_addr == n_head)) ? i_push_data : mem[n_head];
        end
    end

    assign o_rd_data = r_rd;
    assign o_count   = r_count;

endmodule
